// ===== rtl/ctp_pkg.sv =====
`timescale 1ns / 1ps
// Package for the circle tangent point pipeline.
// Shared constants for the top level and the multiplier and divider cells; no dependencies.
package ctp_pkg;

  // Default coordinate width (signed, binary point cancels in the math)
  localparam int COORD_W   = 32;
  // Multiplier digit width used by the partial product cells
  localparam int MUL_DIGIT = 16;
  // Number of tangent coordinates produced per word
  localparam int NLANE     = 4;

  // Lanes of the partial product and divider cells
  typedef enum logic [1:0] {
    LANE_0 = 2'd0,
    LANE_1 = 2'd1,
    LANE_2 = 2'd2,
    LANE_3 = 2'd3
  } lane_t;

endpackage

// ===== rtl/ctp_sqrt_cell.sv =====
`timescale 1ns / 1ps
// One restoring square root step: retires one root bit per cycle while en is high.
// Uses no package items; chained by circle_tangent_points.
module ctp_sqrt_cell #(
  parameter int SW = 33,
  parameter int PW = 8
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              en,
  input  logic              vld_i,
  input  logic [2*SW-1:0]   rad_i,
  input  logic [SW+1:0]     rem_i,
  input  logic [SW-1:0]     root_i,
  input  logic [PW-1:0]     pay_i,
  output logic              vld_r,
  output logic [2*SW-1:0]   rad_r,
  output logic [SW+1:0]     rem_r,
  output logic [SW-1:0]     root_r,
  output logic [PW-1:0]     pay_r
);

  logic [SW+3:0] rem_sh;
  logic [SW+3:0] trial;
  logic [SW+3:0] diff;
  logic          take;
  logic [SW+1:0] rem_nxt;

  // bring in the next two radicand bits, try 4*root+1
  assign rem_sh  = {rem_i, rad_i[2*SW-1 -: 2]};
  assign trial   = {2'b00, root_i, 2'b01};
  assign diff    = rem_sh - trial;
  assign take    = (rem_sh >= trial);
  assign rem_nxt = take ? diff[SW+1:0] : rem_sh[SW+1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (en) begin
      vld_r <= vld_i;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rad_r  <= {rad_i[2*SW-3:0], 2'b00};
      rem_r  <= rem_nxt;
      root_r <= {root_i[SW-2:0], take};
      pay_r  <= pay_i;
    end
  end

endmodule

// ===== rtl/ctp_mul_cell.sv =====
`timescale 1ns / 1ps
// One digit step of the four products p, q, pz, qx (multiply-accumulate).
// Uses ctp_pkg lane codes; chained by circle_tangent_points.
module ctp_mul_cell #(
  parameter int AW  = 33,
  parameter int BW  = 64,
  parameter int DG  = 16,
  parameter int IDX = 0,
  parameter int PRW = 97,
  parameter int PW  = 8
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             en,
  input  logic                             vld_i,
  input  logic [AW-1:0]                    ax_i,
  input  logic [AW-1:0]                    az_i,
  input  logic [BW-1:0]                    rr_i,
  input  logic [BW-1:0]                    rs_i,
  input  logic [ctp_pkg::NLANE-1:0][PRW-1:0] acc_i,
  input  logic [PW-1:0]                    pay_i,
  output logic                             vld_r,
  output logic [AW-1:0]                    ax_r,
  output logic [AW-1:0]                    az_r,
  output logic [BW-1:0]                    rr_r,
  output logic [BW-1:0]                    rs_r,
  output logic [ctp_pkg::NLANE-1:0][PRW-1:0] acc_r,
  output logic [PW-1:0]                    pay_r
);

  localparam int SH = IDX * DG;

  logic [DG-1:0]                      dr;
  logic [DG-1:0]                      ds;
  logic [ctp_pkg::NLANE-1:0][AW+DG-1:0] pp;
  logic [ctp_pkg::NLANE-1:0][PRW-1:0]   acc_nxt;

  assign dr = rr_i[SH +: DG];
  assign ds = rs_i[SH +: DG];

  // p = ax*r^2, q = az*r*s, pz = az*r^2, qx = ax*r*s
  assign pp[ctp_pkg::LANE_0] = ax_i * dr;
  assign pp[ctp_pkg::LANE_1] = az_i * ds;
  assign pp[ctp_pkg::LANE_2] = az_i * dr;
  assign pp[ctp_pkg::LANE_3] = ax_i * ds;

  always_comb begin
    for (int k = 0; k < ctp_pkg::NLANE; k++) begin
      acc_nxt[k] = acc_i[k] + (PRW'(pp[k]) << SH);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (en) begin
      vld_r <= vld_i;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ax_r  <= ax_i;
      az_r  <= az_i;
      rr_r  <= rr_i;
      rs_r  <= rs_i;
      acc_r <= acc_nxt;
      pay_r <= pay_i;
    end
  end

endmodule

// ===== rtl/ctp_div_cell.sv =====
`timescale 1ns / 1ps
// One restoring division step on four lanes sharing one divisor.
// Uses ctp_pkg lane count; chained by circle_tangent_points.
module ctp_div_cell #(
  parameter int DVW = 67,
  parameter int QW  = 32,
  parameter int PW  = 8
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             en,
  input  logic                             vld_i,
  input  logic [ctp_pkg::NLANE-1:0][QW-1:0]  nlo_i,
  input  logic [ctp_pkg::NLANE-1:0][DVW-1:0] rem_i,
  input  logic [ctp_pkg::NLANE-1:0][QW-1:0]  quo_i,
  input  logic [DVW-1:0]                   dv_i,
  input  logic [PW-1:0]                    pay_i,
  output logic                             vld_r,
  output logic [ctp_pkg::NLANE-1:0][QW-1:0]  nlo_r,
  output logic [ctp_pkg::NLANE-1:0][DVW-1:0] rem_r,
  output logic [ctp_pkg::NLANE-1:0][QW-1:0]  quo_r,
  output logic [DVW-1:0]                   dv_r,
  output logic [PW-1:0]                    pay_r
);

  logic [ctp_pkg::NLANE-1:0][DVW:0]   rem_sh;
  logic [ctp_pkg::NLANE-1:0][DVW:0]   diff;
  logic [ctp_pkg::NLANE-1:0]          take;
  logic [ctp_pkg::NLANE-1:0][DVW-1:0] rem_nxt;

  always_comb begin
    for (int k = 0; k < ctp_pkg::NLANE; k++) begin
      rem_sh[k]  = {rem_i[k], nlo_i[k][QW-1]};
      diff[k]    = rem_sh[k] - {1'b0, dv_i};
      take[k]    = (rem_sh[k] >= {1'b0, dv_i});
      rem_nxt[k] = take[k] ? diff[k][DVW-1:0] : rem_sh[k][DVW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (en) begin
      vld_r <= vld_i;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < ctp_pkg::NLANE; k++) begin
        nlo_r[k] <= {nlo_i[k][QW-2:0], 1'b0};
        quo_r[k] <= {quo_i[k][QW-2:0], take[k]};
      end
      rem_r <= rem_nxt;
      dv_r  <= dv_i;
      pay_r <= pay_i;
    end
  end

endmodule

// ===== rtl/circle_tangent_points.sv =====
`timescale 1ns / 1ps
// Tangent points from an outside point to a circle, fully pipelined.
// Depends on ctp_pkg, ctp_sqrt_cell, ctp_mul_cell and ctp_div_cell.
//
//  channel | dir | ports                         | word
//  in      | in  | in_tvalid/in_tready/in_tdata  | cx, cz, radius, px, pz
//  out     | out | out_tvalid/out_tready/out_tdata/out_tuser | 4 coords, no_tangent
//
// One word enters per cycle while in_tready is high. The pipeline depth is
// set mainly by the square root cell row (one root bit per cell) and the
// divider cell row (one quotient bit per cell). Reset is synchronous and
// clears valid bits only. A word behind a stalled output is held in a skid
// stage; the pipeline halts when that stage is full, so in_tready drops the
// cycle after a finished word arrives behind a stalled output word.
module circle_tangent_points #(
  parameter int COORD_WIDTH = ctp_pkg::COORD_W
) (
  input  logic                                         clk,
  input  logic                                         rst_n,
  input  logic                                         in_tvalid,
  output logic                                         in_tready,
  // center_x, center_z, circle_radius, point_x, point_z, zero pad
  input  logic [((5*COORD_WIDTH-1+7)/8)*8-1:0]         in_tdata,
  output logic                                         out_tvalid,
  input  logic                                         out_tready,
  // tangent1_x, tangent1_z, tangent2_x, tangent2_z, zero pad
  output logic [((4*COORD_WIDTH+7)/8)*8-1:0]           out_tdata,
  // no_tangent
  output logic                                         out_tuser
);

  localparam int W    = COORD_WIDTH;
  localparam int NL   = ctp_pkg::NLANE;
  localparam int OUT_DW = ((4*W+7)/8)*8;
  localparam int AW   = W + 1;
  localparam int RW   = W - 1;
  localparam int SQW  = 2*W + 2;
  localparam int R2W  = 2*W - 2;
  localparam int SW   = W + 1;
  localparam int RSW  = 2*W;
  localparam int DG   = ctp_pkg::MUL_DIGIT;
  localparam int ND   = (2*W + DG - 1) / DG;
  localparam int BW   = ND * DG;
  localparam int PRW  = AW + BW;
  localparam int NSW  = PRW + 2;
  localparam int NMW  = PRW + 1;
  localparam int NUMW = NMW + 2;
  localparam int DVW  = SQW + 1;
  localparam int QW   = W;
  localparam int SPW  = SQW + R2W + 2*AW + 2 + 2*W + RW + 1;
  localparam int MPW  = SQW + 2 + 2*W + 1;
  localparam int DPW  = 2*W + NL + 1;

  logic en;

  // ---------------- input fields
  logic signed [W-1:0]  in_cx, in_cz, in_px, in_pz;
  logic [RW-1:0]        in_r;

  assign in_cx = in_tdata[W-1:0];
  assign in_cz = in_tdata[2*W-1:W];
  assign in_r  = in_tdata[3*W-2:2*W];
  assign in_px = in_tdata[4*W-2:3*W-1];
  assign in_pz = in_tdata[5*W-2:4*W-1];

  // ---------------- front stages
  logic                 v1_r, v2_r, v3_r, v4_r, v5_r;
  logic signed [AW-1:0] dx1_r, dz1_r;
  logic [W-1:0]         cx1_r, cz1_r, cx2_r, cz2_r, cx3_r, cz3_r, cx4_r, cz4_r, cx5_r, cz5_r;
  logic [RW-1:0]        r1_r, r2_r, r3_r, r4_r, r5_r;
  logic [AW-1:0]        ax2_r, az2_r, ax3_r, az3_r, ax4_r, az4_r, ax5_r, az5_r;
  logic                 nx2_r, nz2_r, nx3_r, nz3_r, nx4_r, nz4_r, nx5_r, nz5_r;
  logic [SQW-1:0]       sx3_r, sz3_r, d2_4_r, d2_5_r, rad5_r;
  logic [R2W-1:0]       rr3_r, rr4_r, rr5_r;
  logic                 bad5_r;
  logic [SQW-1:0]       sx_nxt, sz_nxt;
  logic [R2W-1:0]       rr_nxt;

  assign sx_nxt = ax2_r * ax2_r;
  assign sz_nxt = az2_r * az2_r;
  assign rr_nxt = r2_r * r2_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
      v5_r <= 1'b0;
    end else if (en) begin
      v1_r <= in_tvalid;
      v2_r <= v1_r;
      v3_r <= v2_r;
      v4_r <= v3_r;
      v5_r <= v4_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      dx1_r  <= AW'(in_cx) - AW'(in_px);
      dz1_r  <= AW'(in_cz) - AW'(in_pz);
      cx1_r  <= in_cx;
      cz1_r  <= in_cz;
      r1_r   <= in_r;
      // magnitude and sign of the offset
      ax2_r  <= dx1_r[AW-1] ? AW'(-dx1_r) : AW'(dx1_r);
      az2_r  <= dz1_r[AW-1] ? AW'(-dz1_r) : AW'(dz1_r);
      nx2_r  <= dx1_r[AW-1];
      nz2_r  <= dz1_r[AW-1];
      cx2_r  <= cx1_r;
      cz2_r  <= cz1_r;
      r2_r   <= r1_r;
      sx3_r  <= sx_nxt;
      sz3_r  <= sz_nxt;
      rr3_r  <= rr_nxt;
      ax3_r  <= ax2_r;
      az3_r  <= az2_r;
      nx3_r  <= nx2_r;
      nz3_r  <= nz2_r;
      cx3_r  <= cx2_r;
      cz3_r  <= cz2_r;
      r3_r   <= r2_r;
      d2_4_r <= sx3_r + sz3_r;
      rr4_r  <= rr3_r;
      ax4_r  <= ax3_r;
      az4_r  <= az3_r;
      nx4_r  <= nx3_r;
      nz4_r  <= nz3_r;
      cx4_r  <= cx3_r;
      cz4_r  <= cz3_r;
      r4_r   <= r3_r;
      rad5_r <= d2_4_r - SQW'(rr4_r);
      bad5_r <= (d2_4_r == '0) || (SQW'(rr4_r) > d2_4_r);
      d2_5_r <= d2_4_r;
      rr5_r  <= rr4_r;
      ax5_r  <= ax4_r;
      az5_r  <= az4_r;
      nx5_r  <= nx4_r;
      nz5_r  <= nz4_r;
      cx5_r  <= cx4_r;
      cz5_r  <= cz4_r;
      r5_r   <= r4_r;
    end
  end

  // ---------------- square root cell row
  logic [SW:0]                 sq_v;
  logic [SW:0][2*SW-1:0]       sq_rad;
  logic [SW:0][SW+1:0]         sq_rem;
  logic [SW:0][SW-1:0]         sq_root;
  logic [SW:0][SPW-1:0]        sq_pay;

  assign sq_v[0]    = v5_r;
  assign sq_rad[0]  = rad5_r;
  assign sq_rem[0]  = '0;
  assign sq_root[0] = '0;
  assign sq_pay[0]  = {d2_5_r, rr5_r, ax5_r, az5_r, nx5_r, nz5_r, cx5_r, cz5_r, r5_r, bad5_r};

  for (genvar i = 0; i < SW; i++) begin : g_sqrt
    ctp_sqrt_cell #(.SW(SW), .PW(SPW)) u_cell (
      .clk    (clk),
      .rst_n  (rst_n),
      .en     (en),
      .vld_i  (sq_v[i]),
      .rad_i  (sq_rad[i]),
      .rem_i  (sq_rem[i]),
      .root_i (sq_root[i]),
      .pay_i  (sq_pay[i]),
      .vld_r  (sq_v[i+1]),
      .rad_r  (sq_rad[i+1]),
      .rem_r  (sq_rem[i+1]),
      .root_r (sq_root[i+1]),
      .pay_r  (sq_pay[i+1])
    );
  end

  logic [SQW-1:0] d2_s;
  logic [R2W-1:0] rr_s;
  logic [AW-1:0]  ax_s, az_s;
  logic           nx_s, nz_s, bad_s;
  logic [W-1:0]   cx_s, cz_s;
  logic [RW-1:0]  r_s;

  assign {d2_s, rr_s, ax_s, az_s, nx_s, nz_s, cx_s, cz_s, r_s, bad_s} = sq_pay[SW];

  // ---------------- r*s
  logic            v6_r;
  logic [RSW-1:0]  rs6_r, rs_nxt;
  logic [R2W-1:0]  rr6_r;
  logic [AW-1:0]   ax6_r, az6_r;
  logic [MPW-1:0]  pay6_r;

  assign rs_nxt = sq_root[SW] * r_s;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v6_r <= 1'b0;
    end else if (en) begin
      v6_r <= sq_v[SW];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rs6_r  <= rs_nxt;
      rr6_r  <= rr_s;
      ax6_r  <= ax_s;
      az6_r  <= az_s;
      pay6_r <= {d2_s, nx_s, nz_s, cx_s, cz_s, bad_s};
    end
  end

  // ---------------- partial product cell row
  logic [ND:0]                  mu_v;
  logic [ND:0][AW-1:0]          mu_ax, mu_az;
  logic [ND:0][BW-1:0]          mu_rr, mu_rs;
  logic [ND:0][NL-1:0][PRW-1:0] mu_acc;
  logic [ND:0][MPW-1:0]         mu_pay;

  assign mu_v[0]   = v6_r;
  assign mu_ax[0]  = ax6_r;
  assign mu_az[0]  = az6_r;
  assign mu_rr[0]  = BW'(rr6_r);
  assign mu_rs[0]  = BW'(rs6_r);
  assign mu_acc[0] = '0;
  assign mu_pay[0] = pay6_r;

  for (genvar i = 0; i < ND; i++) begin : g_mul
    ctp_mul_cell #(
      .AW(AW), .BW(BW), .DG(DG), .IDX(i), .PRW(PRW), .PW(MPW)
    ) u_cell (
      .clk   (clk),
      .rst_n (rst_n),
      .en    (en),
      .vld_i (mu_v[i]),
      .ax_i  (mu_ax[i]),
      .az_i  (mu_az[i]),
      .rr_i  (mu_rr[i]),
      .rs_i  (mu_rs[i]),
      .acc_i (mu_acc[i]),
      .pay_i (mu_pay[i]),
      .vld_r (mu_v[i+1]),
      .ax_r  (mu_ax[i+1]),
      .az_r  (mu_az[i+1]),
      .rr_r  (mu_rr[i+1]),
      .rs_r  (mu_rs[i+1]),
      .acc_r (mu_acc[i+1]),
      .pay_r (mu_pay[i+1])
    );
  end

  logic [SQW-1:0] d2_m;
  logic           nx_m, nz_m, bad_m;
  logic [W-1:0]   cx_m, cz_m;

  assign {d2_m, nx_m, nz_m, cx_m, cz_m, bad_m} = mu_pay[ND];

  // ---------------- numerator combine: sums and differences, then sign
  logic                  v7_r, v8_r, v9_r;
  logic signed [NSW-1:0] spq7_r, dpq7_r, szx7_r, dzx7_r;
  logic                  nx7_r, nz7_r;
  logic [DPW-1:0]        pay7_r;
  logic [SQW-1:0]        d2_7_r, d2_8_r;
  logic [NL-1:0][NMW-1:0] nm8_r;
  logic [DPW-1:0]        pay8_r, pay9_r;
  logic [NL-1:0][NUMW-1:0] num9_r;
  logic [DVW-1:0]        dv9_r;
  logic [NL-1:0]         sa_nxt, sb_nxt;
  logic [NL-1:0][NSW-1:0] sel_nxt;
  logic [NL-1:0][NMW-1:0] nm_nxt;
  logic [NL-1:0]         nn_nxt;

  // lane order: tangent1_x, tangent1_z, tangent2_x, tangent2_z
  always_comb begin
    sa_nxt[ctp_pkg::LANE_0] = nx7_r;
    sb_nxt[ctp_pkg::LANE_0] = nz7_r;
    sa_nxt[ctp_pkg::LANE_1] = nz7_r;
    sb_nxt[ctp_pkg::LANE_1] = !nx7_r;
    sa_nxt[ctp_pkg::LANE_2] = nx7_r;
    sb_nxt[ctp_pkg::LANE_2] = !nz7_r;
    sa_nxt[ctp_pkg::LANE_3] = nz7_r;
    sb_nxt[ctp_pkg::LANE_3] = nx7_r;
    for (int k = 0; k < NL; k++) begin
      if (k == ctp_pkg::LANE_0 || k == ctp_pkg::LANE_2) begin
        sel_nxt[k] = (sa_nxt[k] == sb_nxt[k]) ? spq7_r : dpq7_r;
      end else begin
        sel_nxt[k] = (sa_nxt[k] == sb_nxt[k]) ? szx7_r : dzx7_r;
      end
      nm_nxt[k] = sel_nxt[k][NSW-1] ? NMW'(-sel_nxt[k]) : NMW'(sel_nxt[k]);
      nn_nxt[k] = sa_nxt[k] ^ sel_nxt[k][NSW-1];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v7_r <= 1'b0;
      v8_r <= 1'b0;
      v9_r <= 1'b0;
    end else if (en) begin
      v7_r <= mu_v[ND];
      v8_r <= v7_r;
      v9_r <= v8_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      spq7_r <= NSW'(mu_acc[ND][ctp_pkg::LANE_0]) + NSW'(mu_acc[ND][ctp_pkg::LANE_1]);
      dpq7_r <= NSW'(mu_acc[ND][ctp_pkg::LANE_0]) - NSW'(mu_acc[ND][ctp_pkg::LANE_1]);
      szx7_r <= NSW'(mu_acc[ND][ctp_pkg::LANE_2]) + NSW'(mu_acc[ND][ctp_pkg::LANE_3]);
      dzx7_r <= NSW'(mu_acc[ND][ctp_pkg::LANE_2]) - NSW'(mu_acc[ND][ctp_pkg::LANE_3]);
      nx7_r  <= nx_m;
      nz7_r  <= nz_m;
      d2_7_r <= d2_m;
      pay7_r <= {cx_m, cz_m, {NL{1'b0}}, bad_m};
      nm8_r  <= nm_nxt;
      d2_8_r <= d2_7_r;
      // fill in the sign of each lane's numerator
      pay8_r <= {pay7_r[DPW-1 -: 2*W], nn_nxt, pay7_r[0]};
      // round to nearest: (2*n + d2) / (2*d2)
      for (int k = 0; k < NL; k++) begin
        num9_r[k] <= {1'b0, nm8_r[k], 1'b0} + NUMW'(d2_8_r);
      end
      dv9_r  <= {d2_8_r, 1'b0};
      pay9_r <= pay8_r;
    end
  end

  // ---------------- divider cell row
  logic [QW:0]                  dv_v;
  logic [QW:0][NL-1:0][QW-1:0]  dv_nlo;
  logic [QW:0][NL-1:0][DVW-1:0] dv_rem;
  logic [QW:0][NL-1:0][QW-1:0]  dv_quo;
  logic [QW:0][DVW-1:0]         dv_dv;
  logic [QW:0][DPW-1:0]         dv_pay;

  assign dv_v[0]   = v9_r;
  assign dv_dv[0]  = dv9_r;
  assign dv_pay[0] = pay9_r;
  assign dv_quo[0] = '0;

  always_comb begin
    for (int k = 0; k < NL; k++) begin
      dv_nlo[0][k] = num9_r[k][QW-1:0];
      dv_rem[0][k] = num9_r[k][QW +: DVW];
    end
  end

  for (genvar i = 0; i < QW; i++) begin : g_div
    ctp_div_cell #(.DVW(DVW), .QW(QW), .PW(DPW)) u_cell (
      .clk   (clk),
      .rst_n (rst_n),
      .en    (en),
      .vld_i (dv_v[i]),
      .nlo_i (dv_nlo[i]),
      .rem_i (dv_rem[i]),
      .quo_i (dv_quo[i]),
      .dv_i  (dv_dv[i]),
      .pay_i (dv_pay[i]),
      .vld_r (dv_v[i+1]),
      .nlo_r (dv_nlo[i+1]),
      .rem_r (dv_rem[i+1]),
      .quo_r (dv_quo[i+1]),
      .dv_r  (dv_dv[i+1]),
      .pay_r (dv_pay[i+1])
    );
  end

  // ---------------- offset from center, saturation and zeroing of no-tangent words
  logic [W-1:0]            cx_d, cz_d;
  logic [NL-1:0]           nn_d;
  logic                    bad_d;
  logic [NL-1:0][W+1:0]    sum_nxt;
  logic [NL-1:0][W-1:0]    crd_nxt;
  logic [W+1:0]            sat_hi, sat_lo;
  logic                    v10_r;
  logic [NL-1:0][W-1:0]    crd10_r;
  logic                    bad10_r;

  assign {cx_d, cz_d, nn_d, bad_d} = dv_pay[QW];
  assign sat_hi = (W+2)'({1'b0, {(W-1){1'b1}}});
  assign sat_lo = ~sat_hi;

  always_comb begin
    for (int k = 0; k < NL; k++) begin
      if (k == ctp_pkg::LANE_0 || k == ctp_pkg::LANE_2) begin
        sum_nxt[k] = {{2{cx_d[W-1]}}, cx_d};
      end else begin
        sum_nxt[k] = {{2{cz_d[W-1]}}, cz_d};
      end
      sum_nxt[k] = nn_d[k] ? sum_nxt[k] + (W+2)'(dv_quo[QW][k])
                           : sum_nxt[k] - (W+2)'(dv_quo[QW][k]);
      priority if ($signed(sum_nxt[k]) > $signed(sat_hi)) begin
        crd_nxt[k] = sat_hi[W-1:0];
      end else if ($signed(sum_nxt[k]) < $signed(sat_lo)) begin
        crd_nxt[k] = sat_lo[W-1:0];
      end else begin
        crd_nxt[k] = sum_nxt[k][W-1:0];
      end
      if (bad_d) begin
        crd_nxt[k] = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v10_r <= 1'b0;
    end else if (en) begin
      v10_r <= dv_v[QW];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      crd10_r <= crd_nxt;
      bad10_r <= bad_d;
    end
  end

  // ---------------- output register and skid stage
  logic              out_vld_r, skid_vld_r;
  logic [OUT_DW-1:0] out_dat_r, skid_dat_r, pipe_dat;
  logic              out_usr_r, skid_usr_r;
  logic              out_free;

  assign pipe_dat = OUT_DW'({crd10_r[ctp_pkg::LANE_3], crd10_r[ctp_pkg::LANE_2],
                             crd10_r[ctp_pkg::LANE_1], crd10_r[ctp_pkg::LANE_0]});
  assign out_free = out_tready || !out_vld_r;
  assign en       = !skid_vld_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r  <= 1'b0;
      skid_vld_r <= 1'b0;
    end else if (out_free) begin
      // drain skid first, else take the pipeline word
      out_vld_r  <= skid_vld_r || v10_r;
      skid_vld_r <= 1'b0;
    end else if (en && v10_r) begin
      skid_vld_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (out_free) begin
      out_dat_r <= skid_vld_r ? skid_dat_r : pipe_dat;
      out_usr_r <= skid_vld_r ? skid_usr_r : bad10_r;
    end
    if (en && !out_free) begin
      skid_dat_r <= pipe_dat;
      skid_usr_r <= bad10_r;
    end
  end

  assign in_tready  = en;
  assign out_tvalid = out_vld_r;
  assign out_tdata  = out_dat_r;
  assign out_tuser  = out_usr_r;

endmodule

// ===== rtl/ctp_checker.sv =====
`timescale 1ns / 1ps
// Port-level checker for circle_tangent_points, bound to the top level.
// Sees only the top-level ports; no package dependency.
module ctp_checker #(
  parameter int OUT_DW = 128
) (
  input logic              clk,
  input logic              rst_n,
  input logic              in_tvalid,
  input logic              in_tready,
  input logic              out_tvalid,
  input logic              out_tready,
  input logic [OUT_DW-1:0] out_tdata,
  input logic              out_tuser
);

  // reset empties the output
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("output valid after reset");

  // a word with no tangent carries zero coordinates
  a_flag_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser |-> out_tdata == '0)
    else $error("no_tangent word with nonzero coordinates");

  // skid stage only fills behind a waiting output word
  a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !out_tvalid |-> in_tready)
    else $error("input stalled with empty output");

  // hold a stalled word
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("stalled output word changed");

endmodule

bind circle_tangent_points ctp_checker #(.OUT_DW(OUT_DW)) u_ctp_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser)
);
